/* src/prmb_pkg.sv */
`default_nettype none

package prmb_pkg;

   // Frame geometry and storage
   localparam int MAX_WIDTH      = 256;
   localparam int MAX_HEIGHT     = 256;
   localparam int COUNT_BITS     = 24;
   localparam int COORD_BITS     = 8;
   localparam int DIM_BITS       = 9;
   localparam int STORE_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
   localparam int CHAN_BITS      = 32;
   localparam int SEEN_BITS      = 24;

   // Running mean arithmetic
   localparam int MAG_BITS       = CHAN_BITS + COUNT_BITS;
   localparam int DIVISOR_BITS   = COUNT_BITS + 1;
   localparam int DIV_STEPS      = CHAN_BITS;
   localparam int STEP_BITS      = $clog2(DIV_STEPS);
   localparam int LANES          = 3;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Actions
   localparam logic [1:0] ACT_AVERAGE    = 2'd0;
   localparam logic [1:0] ACT_ACCUMULATE = 2'd1;
   localparam logic [1:0] ACT_READ       = 2'd2;
   localparam logic [1:0] ACT_CLEAR      = 2'd3;

   // Result status
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic [1:0]                  action;
      logic [COORD_BITS-1:0]       pixel_x;
      logic [COORD_BITS-1:0]       pixel_y;
      logic signed [CHAN_BITS-1:0] sample_red;
      logic signed [CHAN_BITS-1:0] sample_green;
      logic signed [CHAN_BITS-1:0] sample_blue;
   } req_type;

   typedef struct packed {
      logic                        status;
      logic signed [CHAN_BITS-1:0] value_red;
      logic signed [CHAN_BITS-1:0] value_green;
      logic signed [CHAN_BITS-1:0] value_blue;
      logic [SEEN_BITS-1:0]        samples_seen;
   } rsp_type;

   // One stored pixel
   typedef struct packed {
      logic [COUNT_BITS-1:0]       count;
      logic signed [CHAN_BITS-1:0] red;
      logic signed [CHAN_BITS-1:0] green;
      logic signed [CHAN_BITS-1:0] blue;
   } entry_type;

   // Divider lane control
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

endpackage

`default_nettype wire

/* src/prmb_div.sv */
`default_nettype none

module prmb_div
   import prmb_pkg::*;
(
   input  wire                              clock,
   input  div_ctrl_type                     ctrl,
   input  wire logic signed [MAG_BITS-1:0]  num_in,
   input  wire logic [DIVISOR_BITS-1:0]     divisor_in,
   output logic signed [CHAN_BITS-1:0]      quotient
);

   logic                    neg_ff, neg_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [CHAN_BITS-1:0]    quo_ff, quo_in;

   logic [MAG_BITS-1:0]     mag;
   logic [DIVISOR_BITS:0]   trial;
   logic [DIVISOR_BITS:0]   diff;

   // Restoring division of the magnitude, one quotient bit per step; the
   // upper part of the dividend is known to be below the divisor
   always_comb begin
      mag    = num_in[MAG_BITS-1] ? MAG_BITS'(-num_in) : MAG_BITS'(num_in);
      trial  = {rem_ff, quo_ff[CHAN_BITS-1]};
      diff   = trial - {1'b0, divisor_in};
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         neg_in = num_in[MAG_BITS-1];
         rem_in = DIVISOR_BITS'(mag[MAG_BITS-1:CHAN_BITS]);
         quo_in = mag[CHAN_BITS-1:0];
      end else if (ctrl.step) begin
         if (!diff[DIVISOR_BITS]) begin
            rem_in = diff[DIVISOR_BITS-1:0];
         end else begin
            rem_in = trial[DIVISOR_BITS-1:0];
         end
         quo_in = {quo_ff[CHAN_BITS-2:0], ~diff[DIVISOR_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Apply the sign: truncation toward zero
   assign quotient = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule

`default_nettype wire

/* src/pixel_running_mean_buffer.sv */
`default_nettype none

// Per-pixel radiance store for progressive rendering.
// Request channel (req_valid / req_stall / req_data) takes one transaction per
// action: average a sample into the running mean, accumulate a sample with
// saturation, read a pixel, or clear all pixels in the configured frame.
// Each transaction gives exactly one response on rsp_valid / rsp_stall /
// rsp_data with the pixel state after the action, or status 1 when the
// coordinate lies outside frame_width x frame_height.
// States per transaction: average runs index, read, exec, add, load, div
// (three 32-step restoring divider lanes, one bit per cycle), finish and
// done; accumulate and read run index, read, exec and done; out of range
// runs index and done; clear sweeps the frame (one store row written per
// cycle through the single memory port) and then done. The response is
// registered; the response and the next transaction can go at the same edge.
// Frame size is written through csr_wr_en / csr_index / csr_wr_data; the user
// must write it only while the block is idle, which the block does not enforce;
// 0 acts as 1, values above 256 act as 256. After reset the store is swept to zero
// with req_stall high. A stalled response stays in the output register; the next
// transaction is still accepted and proceeds until its own response is ready.

module pixel_running_mean_buffer
   import prmb_pkg::*;
(
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  req_type                           req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output rsp_type                           rsp_data,
   input  wire                               csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [DIM_BITS-1:0]          csr_wr_data
);

   localparam logic [3:0] S_SWEEP  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_INDEX  = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_EXEC   = 4'd4;
   localparam logic [3:0] S_ADD    = 4'd5;
   localparam logic [3:0] S_LOAD   = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam logic [DIM_BITS-1:0]   WIDTH_LIMIT  = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0]   HEIGHT_LIMIT = DIM_BITS'(MAX_HEIGHT);
   localparam logic [ADDR_BITS-1:0]  LAST_ADDR    = ADDR_BITS'(STORE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
   localparam logic [STEP_BITS-1:0]  LAST_STEP    = STEP_BITS'(DIV_STEPS - 1);

   function automatic logic [DIM_BITS-1:0] dim_clamp(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // Control registers
   logic [3:0]              state_ff, state_in;
   logic [DIM_BITS-1:0]     frame_width_ff, frame_width_in;
   logic [DIM_BITS-1:0]     frame_height_ff, frame_height_in;
   logic [ADDR_BITS-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic [ADDR_BITS-1:0]    sweep_last_ff, sweep_last_in;
   logic                    sweep_reply_ff, sweep_reply_in;
   logic [STEP_BITS-1:0]    step_cnt_ff, step_cnt_in;
   logic                    wr_pending_ff, wr_pending_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers
   req_type                 req_ff, req_in;
   logic [ADDR_BITS-1:0]    idx_ff, idx_in;
   logic                    status_ff, status_in;
   entry_type               wr_entry_ff, wr_entry_in;
   logic [DIVISOR_BITS-1:0] divisor_ff, divisor_in;
   logic signed [MAG_BITS-1:0] prod_ff [0:LANES-1];
   logic signed [MAG_BITS-1:0] prod_in [0:LANES-1];
   logic signed [MAG_BITS-1:0] num_ff  [0:LANES-1];
   logic signed [MAG_BITS-1:0] num_in  [0:LANES-1];
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Store
   entry_type               store_mem [0:STORE_DEPTH-1];
   entry_type               mem_rd_ff;
   logic                    mem_we;
   logic [ADDR_BITS-1:0]    mem_addr;
   entry_type               mem_wdata;

   // Lane views
   logic signed [CHAN_BITS-1:0] old_chan [0:LANES-1];
   logic signed [CHAN_BITS-1:0] smp_chan [0:LANES-1];
   logic signed [CHAN_BITS-1:0] quo_chan [0:LANES-1];
   logic signed [CHAN_BITS-1:0] acc_chan [0:LANES-1];
   logic signed [MAG_BITS:0]    prod_full [0:LANES-1];
   logic signed [CHAN_BITS:0]   sum_chan [0:LANES-1];
   div_ctrl_type                div_ctrl;

   logic [2*DIM_BITS-1:0]   area;
   logic [ADDR_BITS:0]      idx_calc;
   logic                    out_of_range;

   assign old_chan[0] = mem_rd_ff.red;
   assign old_chan[1] = mem_rd_ff.green;
   assign old_chan[2] = mem_rd_ff.blue;
   assign smp_chan[0] = req_ff.sample_red;
   assign smp_chan[1] = req_ff.sample_green;
   assign smp_chan[2] = req_ff.sample_blue;

   // Divider lanes, one per channel
   for (genvar c = 0; c < LANES; c++) begin : g_lane
      prmb_div u_div (
         .clock      (clock),
         .ctrl       (div_ctrl),
         .num_in     (num_ff[c]),
         .divisor_in (divisor_ff),
         .quotient   (quo_chan[c])
      );
   end

   // Lane arithmetic: product for the mean, saturating sum for accumulate
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         prod_full[c] = old_chan[c] * $signed({1'b0, mem_rd_ff.count});
         sum_chan[c]  = {old_chan[c][CHAN_BITS-1], old_chan[c]} +
                        {smp_chan[c][CHAN_BITS-1], smp_chan[c]};
         if (sum_chan[c][CHAN_BITS] != sum_chan[c][CHAN_BITS-1]) begin
            acc_chan[c] = sum_chan[c][CHAN_BITS] ? $signed({1'b1, {(CHAN_BITS-1){1'b0}}})
                                                 : $signed({1'b0, {(CHAN_BITS-1){1'b1}}});
         end else begin
            acc_chan[c] = sum_chan[c][CHAN_BITS-1:0];
         end
      end
   end

   assign area         = (2*DIM_BITS)'(frame_width_ff) * (2*DIM_BITS)'(frame_height_ff);
   assign idx_calc     = (ADDR_BITS+1)'((ADDR_BITS+1)'(req_ff.pixel_y) *
                                        (ADDR_BITS+1)'(frame_width_ff)) +
                         (ADDR_BITS+1)'(req_ff.pixel_x);
   assign out_of_range = ({1'b0, req_ff.pixel_x} >= frame_width_ff) ||
                         ({1'b0, req_ff.pixel_y} >= frame_height_ff);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      sweep_last_in  = sweep_last_ff;
      sweep_reply_in = sweep_reply_ff;
      step_cnt_in    = step_cnt_ff;
      wr_pending_in  = wr_pending_ff;
      req_in         = req_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      wr_entry_in    = wr_entry_ff;
      divisor_in     = divisor_ff;
      prod_in        = prod_ff;
      num_in         = num_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_data_in    = rsp_data_ff;
      div_ctrl       = '0;
      mem_we         = 1'b0;
      mem_addr       = idx_ff;
      mem_wdata      = '0;

      case (state_ff)
         S_SWEEP: begin
            // Zero one row per cycle
            mem_we   = 1'b1;
            mem_addr = sweep_cnt_ff;
            if (sweep_cnt_ff == sweep_last_ff) begin
               if (sweep_reply_ff) begin
                  status_in     = STATUS_DONE;
                  wr_entry_in   = '0;
                  wr_pending_in = 1'b0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               sweep_cnt_in = sweep_cnt_ff + ADDR_BITS'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.action == ACT_CLEAR) begin
                  sweep_cnt_in   = '0;
                  sweep_last_in  = ADDR_BITS'(area - (2*DIM_BITS)'(1));
                  sweep_reply_in = 1'b1;
                  state_in       = S_SWEEP;
               end else begin
                  state_in = S_INDEX;
               end
            end
         end
         S_INDEX: begin
            if (out_of_range) begin
               status_in     = STATUS_RANGE;
               wr_entry_in   = '0;
               wr_pending_in = 1'b0;
               state_in      = S_DONE;
            end else begin
               status_in = STATUS_DONE;
               idx_in    = idx_calc[ADDR_BITS-1:0];
               state_in  = S_READ;
            end
         end
         S_READ: begin
            // Address presented; entry lands in mem_rd_ff
            state_in = S_EXEC;
         end
         S_EXEC: begin
            divisor_in = {1'b0, mem_rd_ff.count} + DIVISOR_BITS'(1);
            case (req_ff.action)
               ACT_AVERAGE: begin
                  for (int c = 0; c < LANES; c++) begin
                     prod_in[c] = prod_full[c][MAG_BITS-1:0];
                  end
                  wr_entry_in.count = (mem_rd_ff.count == COUNT_MAX) ? COUNT_MAX :
                                      mem_rd_ff.count + COUNT_BITS'(1);
                  state_in = S_ADD;
               end
               ACT_ACCUMULATE: begin
                  wr_entry_in.count = mem_rd_ff.count;
                  wr_entry_in.red   = acc_chan[0];
                  wr_entry_in.green = acc_chan[1];
                  wr_entry_in.blue  = acc_chan[2];
                  wr_pending_in     = 1'b1;
                  state_in          = S_DONE;
               end
               default: begin
                  wr_entry_in   = mem_rd_ff;
                  wr_pending_in = 1'b0;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_ADD: begin
            for (int c = 0; c < LANES; c++) begin
               num_in[c] = prod_ff[c] + MAG_BITS'(smp_chan[c]);
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            div_ctrl.load = 1'b1;
            step_cnt_in   = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            div_ctrl.step = 1'b1;
            step_cnt_in   = step_cnt_ff + STEP_BITS'(1);
            if (step_cnt_ff == LAST_STEP) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            wr_entry_in.red   = quo_chan[0];
            wr_entry_in.green = quo_chan[1];
            wr_entry_in.blue  = quo_chan[2];
            wr_pending_in     = 1'b1;
            state_in          = S_DONE;
         end
         S_DONE: begin
            // Write back, then hand the transaction to the output register
            mem_we    = wr_pending_ff;
            mem_wdata = wr_entry_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.value_red    = wr_entry_ff.red;
               rsp_data_in.value_green  = wr_entry_ff.green;
               rsp_data_in.value_blue   = wr_entry_ff.blue;
               rsp_data_in.samples_seen = SEEN_BITS'(wr_entry_ff.count);
               wr_pending_in            = 1'b0;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = dim_clamp(csr_wr_data, WIDTH_LIMIT);
            CSR_FRAME_HEIGHT: frame_height_in = dim_clamp(csr_wr_data, HEIGHT_LIMIT);
            default: begin
               frame_width_in = frame_width_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         frame_width_ff  <= WIDTH_LIMIT;
         frame_height_ff <= HEIGHT_LIMIT;
         sweep_cnt_ff    <= '0;
         sweep_last_ff   <= LAST_ADDR;
         sweep_reply_ff  <= 1'b0;
         step_cnt_ff     <= '0;
         wr_pending_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         sweep_cnt_ff    <= sweep_cnt_in;
         sweep_last_ff   <= sweep_last_in;
         sweep_reply_ff  <= sweep_reply_in;
         step_cnt_ff     <= step_cnt_in;
         wr_pending_ff   <= wr_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      wr_entry_ff <= wr_entry_in;
      divisor_ff  <= divisor_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Pixel store, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= store_mem[mem_addr];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
